// ===== src/olpd_pkg.sv =====
// Shared types and constants for the ordered list block.
package olpd_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SHOW   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_ELEMENT  = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_REMOVE,
    FSM_SHOW
  } fsm_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_MATCH,
    CELL_PULL,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [DATA_W-1:0]  value;
    logic [CNT_W-1:0]          count;
  } cell_cmd_t;

endpackage

// ===== src/olpd_cell.sv =====
// One list position: holds an entry and trades it with its neighbors.
module olpd_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  olpd_pkg::cell_cmd_t              cmd_i,
  input  logic [olpd_pkg::IDX_W-1:0]       idx_i,
  input  logic signed [olpd_pkg::DATA_W-1:0] prev_i,
  input  logic signed [olpd_pkg::DATA_W-1:0] next_i,
  input  logic signed [olpd_pkg::DATA_W-1:0] head_i,
  input  logic                             found_i,
  output logic signed [olpd_pkg::DATA_W-1:0] data_o,
  output logic                             found_o
);
  import olpd_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     hit_q, hit_d;
  logic [CNT_W-1:0]         pos;
  logic                     in_use;
  logic                     at_tail;

  assign pos     = CNT_W'(idx_i);
  assign in_use  = pos < cmd_i.count;
  assign at_tail = (pos == cmd_i.count - CNT_W'(1));
  // a match here or closer to the head pulls this position from the next one
  assign found_o = found_i | hit_q;
  assign data_o  = data_q;

  always_comb begin
    data_d = data_q;
    hit_d  = hit_q;
    case (cmd_i.op)
      CELL_PUSH:   data_d = prev_i;
      CELL_MATCH:  hit_d  = in_use && (data_q == cmd_i.value);
      CELL_PULL: begin
        if (found_o) begin
          data_d = next_i;
        end
        hit_d = 1'b0;
      end
      // wrap the head around to the tail so a full pass restores the order
      CELL_ROTATE: data_d = at_tail ? head_i : next_i;
      default:     data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

endmodule

// ===== src/ordered_list_push_front_delete_match.sv =====
// Top level: ordered list held in a chain of cells, stream in and out.
// Add: result registered in the cycle after acceptance; next item accepted the cycle after if the output is ready.
// Remove: compare in every cell, then close the gap once the output is ready; the result is registered with the close.
// Show: one entry per cycle while the output is ready, from head to tail as the rotating chain passes the head.
// Throughput bounded by the output register; one item in flight at a time.
// Reset (async, active low) empties the list; entry storage is not cleared.
module ordered_list_push_front_delete_match (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic signed [olpd_pkg::DATA_W-1:0] s_axis_tdata,  // value
  input  logic [1:0]                         s_axis_tuser,  // action
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic signed [olpd_pkg::DATA_W-1:0] m_axis_tdata,  // element
  output logic [2:0]                         m_axis_tuser,  // status
  output logic                               m_axis_tlast
);
  import olpd_pkg::*;

  fsm_e                     state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         show_q, show_d;
  logic signed [DATA_W-1:0] val_q, val_d;

  logic                     out_valid_q, out_valid_d;
  status_e                  out_status_q, out_status_d;
  logic signed [DATA_W-1:0] out_elem_q, out_elem_d;
  logic                     out_last_q, out_last_d;

  logic                     out_ready;
  logic                     accept;
  logic                     load;
  cell_cmd_t                cmd;

  logic signed [DATA_W-1:0] data_w [DEPTH];
  logic                     found_w [DEPTH+1];

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == FSM_IDLE) && out_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign found_w[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_s;
    logic signed [DATA_W-1:0] next_s;
    if (i == 0) begin : g_first
      assign prev_s = s_axis_tdata;
    end else begin : g_mid
      assign prev_s = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_s = data_w[i];
    end else begin : g_inner
      assign next_s = data_w[i+1];
    end
    olpd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .idx_i   (IDX_W'(i)),
      .prev_i  (prev_s),
      .next_i  (next_s),
      .head_i  (data_w[0]),
      .found_i (found_w[i]),
      .data_o  (data_w[i]),
      .found_o (found_w[i+1])
    );
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    show_d       = show_q;
    val_d        = val_q;
    cmd.op       = CELL_HOLD;
    cmd.value    = s_axis_tdata;
    cmd.count    = count_q;
    load         = 1'b0;
    out_status_d = out_status_q;
    out_elem_d   = out_elem_q;
    out_last_d   = out_last_q;

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          case (action_e'(s_axis_tuser))
            ACT_ADD: begin
              load         = 1'b1;
              out_elem_d   = s_axis_tdata;
              out_last_d   = 1'b1;
              if (count_q == CNT_W'(DEPTH)) begin
                out_status_d = ST_FULL;
              end else begin
                cmd.op       = CELL_PUSH;
                count_d      = count_q + CNT_W'(1);
                out_status_d = ST_ADDED;
              end
            end
            ACT_REMOVE: begin
              cmd.op  = CELL_MATCH;
              val_d   = s_axis_tdata;
              state_d = FSM_REMOVE;
            end
            ACT_SHOW: begin
              if (count_q == '0) begin
                load         = 1'b1;
                out_status_d = ST_EMPTY;
                out_elem_d   = '0;
                out_last_d   = 1'b1;
              end else begin
                show_d  = '0;
                state_d = FSM_SHOW;
              end
            end
            default: ;  // unused action: drop silently
          endcase
        end
      end

      FSM_REMOVE: begin
        if (out_ready) begin
          cmd.op     = CELL_PULL;
          load       = 1'b1;
          out_elem_d = val_q;
          out_last_d = 1'b1;
          if (found_w[DEPTH]) begin
            count_d      = count_q - CNT_W'(1);
            out_status_d = ST_REMOVED;
          end else begin
            out_status_d = ST_NOTFOUND;
          end
          state_d = FSM_IDLE;
        end
      end

      FSM_SHOW: begin
        if (out_ready) begin
          cmd.op       = CELL_ROTATE;
          load         = 1'b1;
          out_status_d = ST_ELEMENT;
          out_elem_d   = data_w[0];
          out_last_d   = (show_q == count_q - CNT_W'(1));
          show_d       = show_q + CNT_W'(1);
          if (show_q == count_q - CNT_W'(1)) begin
            state_d = FSM_IDLE;
          end
        end
      end

      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      show_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      show_q      <= show_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q        <= val_d;
    out_status_q <= out_status_d;
    out_elem_q   <= out_elem_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_elem_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == FSM_IDLE))
    else $error("input taken while busy");

  a_remove_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_REMOVE) && out_ready |=> (state_q == FSM_IDLE) && m_axis_tvalid)
    else $error("remove did not finish");

  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser == ACT_ADD) && (count_q != CNT_W'(DEPTH))
    |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("add did not grow the list");

  a_show_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_SHOW) && out_ready && (show_q == count_q - CNT_W'(1))
    |=> m_axis_tlast && (state_q == FSM_IDLE))
    else $error("show pass did not end on the tail");
`endif

endmodule

// ===== tb/list_checker.sv =====
// Checker for the ordered list block: tracks the list, predicts results, compares them.
`timescale 1ns / 100ps

module list_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  input  logic                               s_tready_i,
  input  logic signed [olpd_pkg::DATA_W-1:0] s_tdata_i,   // value
  input  logic [1:0]                         s_tuser_i,   // action
  input  logic                               m_tvalid_i,
  input  logic                               m_tready_i,
  input  logic signed [olpd_pkg::DATA_W-1:0] m_tdata_i,   // element
  input  logic [2:0]                         m_tuser_i,   // status
  input  logic                               m_tlast_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 item_count_o,
  output int                                 result_count_o
);
  import olpd_pkg::*;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } list_result_t;

  logic signed [DATA_W-1:0] shadow_list [DEPTH];
  int                       shadow_count;
  list_result_t             expected_q [$];
  int                       fails;
  int                       items;
  int                       results;
  list_result_t             want;

  function automatic void push_result(input status_e st, input logic signed [DATA_W-1:0] el,
                                      input logic lst);
    list_result_t r;
    r.status  = st;
    r.element = el;
    r.last    = lst;
    expected_q.push_back(r);
  endfunction

  // Update the shadow list for one accepted transaction and queue what it produces.
  function automatic void apply_list_action(input action_e act,
                                            input logic signed [DATA_W-1:0] val);
    int pos;
    pos = 0;
    case (act)
      ACT_ADD: begin
        if (shadow_count >= DEPTH) begin
          push_result(ST_FULL, val, 1'b1);
        end else begin
          for (int i = shadow_count; i > 0; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[0] = val;
          shadow_count++;
          push_result(ST_ADDED, val, 1'b1);
        end
      end
      ACT_REMOVE: begin
        while (pos < shadow_count && shadow_list[pos] != val) pos++;
        if (pos >= shadow_count) begin
          push_result(ST_NOTFOUND, val, 1'b1);
        end else begin
          for (int i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
          push_result(ST_REMOVED, val, 1'b1);
        end
      end
      ACT_SHOW: begin
        if (shadow_count == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++)
            push_result(ST_ELEMENT, shadow_list[i], (i + 1 == shadow_count));
        end
      end
      default: ;  // unused code: dropped without a result
    endcase
  endfunction

  function automatic void report(input string field, input longint exp_v, input longint act_v);
    fails++;
    $display("%0t mismatch %s: expected %0d, actual %0d", $time, field, exp_v, act_v);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      shadow_count = 0;
      fails        = 0;
      items        = 0;
      results      = 0;
      for (int i = 0; i < DEPTH; i++) shadow_list[i] = '0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        items++;
        apply_list_action(action_e'(s_tuser_i), s_tdata_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        results++;
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t unexpected result: expected none, actual status %0d element %0d",
                   $time, m_tuser_i, m_tdata_i);
        end else begin
          want = expected_q.pop_front();
          if (m_tuser_i != want.status) report("status", want.status, m_tuser_i);
          if (m_tdata_i != want.element) report("element", want.element, m_tdata_i);
          if (m_tlast_i != want.last) report("last", want.last, m_tlast_i);
        end
      end
    end
    fail_count_o   <= fails;
    pending_o      <= expected_q.size();
    item_count_o   <= items;
    result_count_o <= results;
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the ordered list block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import olpd_pkg::*;

  localparam int LIMIT     = 200_000;
  localparam int HOLD_OFF  = 300;
  localparam int N_RANDOM  = 73;

  logic                     clk;
  logic                     rst_n;
  logic                     s_tvalid;
  logic                     s_tready;
  logic signed [DATA_W-1:0] s_tdata;
  logic [1:0]               s_tuser;
  logic                     m_tvalid;
  logic                     m_tready;
  logic signed [DATA_W-1:0] m_tdata;
  logic [2:0]               m_tuser;
  logic                     m_tlast;

  int fail_count;
  int pending;
  int item_count;
  int result_count;
  int cycle_cnt;
  bit idle_en;
  int stall_req;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  ordered_list_push_front_delete_match dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  list_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_tvalid_i     (s_tvalid),
    .s_tready_i     (s_tready),
    .s_tdata_i      (s_tdata),
    .s_tuser_i      (s_tuser),
    .m_tvalid_i     (m_tvalid),
    .m_tready_i     (m_tready),
    .m_tdata_i      (m_tdata),
    .m_tuser_i      (m_tuser),
    .m_tlast_i      (m_tlast),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .item_count_o   (item_count),
    .result_count_o (result_count)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_cnt, pending);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Offer one transaction, idling first at random; return at the accepting edge.
  task automatic send_item(input action_e act, input logic signed [DATA_W-1:0] val);
    while (idle_en && $urandom_range(99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= val;
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
  endtask

  // A small pool so removes hit, with extremes and fully random words.
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(9))
      0:       v = 32'sh8000_0000;
      1:       v = 32'sh7FFF_FFFF;
      2:       v = '0;
      3:       v = -32'sd1;
      4, 5, 6: v = $urandom_range(7);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Receiver: random backpressure, plus a long hold-off on request.
  initial begin
    int seen;
    int hold;
    seen     = 0;
    hold     = 0;
    m_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (seen != stall_req) begin
        seen = stall_req;
        hold = HOLD_OFF;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (idle_en) begin
        m_tready <= ($urandom_range(99) >= 31);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int      r;
    int      add_w;
    int      rem_w;
    action_e act;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = ACT_NONE;
    idle_en   = 1'b1;
    stall_req = 0;
    cycle_cnt = 0;
    rst_n     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list corners and the unused code, then four extreme words and a show.
    send_item(ACT_SHOW, 32'sd5);
    send_item(ACT_REMOVE, 32'sd5);
    send_item(ACT_NONE, -32'sd1);
    send_item(ACT_ADD, 32'sh8000_0000);
    send_item(ACT_ADD, 32'sh7FFF_FFFF);
    send_item(ACT_ADD, '0);
    send_item(ACT_ADD, -32'sd1);
    send_item(ACT_SHOW, '0);
    // Middle, miss, head and tail removal, then duplicates.
    send_item(ACT_REMOVE, '0);
    send_item(ACT_REMOVE, 32'sd123);
    send_item(ACT_REMOVE, -32'sd1);
    send_item(ACT_REMOVE, 32'sh8000_0000);
    send_item(ACT_ADD, 32'sd7);
    send_item(ACT_ADD, 32'sd7);
    send_item(ACT_REMOVE, 32'sd7);
    send_item(ACT_SHOW, '1);
    // Fill up, overflow, list the full store, then remove from it.
    for (int i = 0; i < DEPTH - 2; i++) send_item(ACT_ADD, pick_value());
    send_item(ACT_ADD, 32'sd42);
    send_item(ACT_SHOW, '0);
    send_item(ACT_REMOVE, 32'sh7FFF_FFFF);

    // Hold the output off while listing, so the block backs up its input.
    stall_req = stall_req + 1;
    repeat (3) send_item(ACT_SHOW, '0);
    send_item(ACT_ADD, 32'sd99);

    for (int k = 0; k < N_RANDOM; k++) begin
      idle_en = !(k >= 40 && k < 70);
      if (k < 35) begin
        add_w = 25;
        rem_w = 50;
      end else if (k < 60) begin
        add_w = 55;
        rem_w = 25;
      end else begin
        add_w = 40;
        rem_w = 35;
      end
      r = $urandom_range(99);
      if (r < add_w)              act = ACT_ADD;
      else if (r < add_w + rem_w) act = ACT_REMOVE;
      else if (r < 95)            act = ACT_SHOW;
      else                        act = ACT_NONE;
      send_item(act, pick_value());
    end
    s_tvalid <= 1'b0;
    idle_en = 1'b1;

    // let the checker count the last transaction before waiting on it
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d list transactions and %0d results: empty, full, duplicate",
             item_count, result_count);
    $display("and missing values, extreme words, and a long output hold-off.");
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/olpd_pkg.sv
src/olpd_cell.sv
src/ordered_list_push_front_delete_match.sv
tb/list_checker.sv
tb/tb_top.sv
